@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the point test checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BPT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that an antecedent forces a consequent on the same edge.
`define BPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent forces a consequent on the next edge.
`define BPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bpt_pkg.sv @@
// ---------------------------------------------------------------------------
// bpt_pkg
// Types and constants of the barycentric point-in-triangle test unit.
// ---------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

  localparam int unsigned FIELD_WIDTH        = 16;
  localparam int unsigned WEIGHT_WIDTH       = 32;
  localparam int unsigned COORD_WIDTH_DEF    = 16;
  localparam int unsigned FRACTION_BITS_DEF  = 16;
  // quotient bits kept by the divider chain; the magnitude clips at 2^(QUOT_BITS-1)
  localparam int unsigned QUOT_BITS          = 61;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] va_x;
    logic signed [FIELD_WIDTH-1:0] va_y;
    logic signed [FIELD_WIDTH-1:0] va_z;
    logic signed [FIELD_WIDTH-1:0] vb_x;
    logic signed [FIELD_WIDTH-1:0] vb_y;
    logic signed [FIELD_WIDTH-1:0] vb_z;
    logic signed [FIELD_WIDTH-1:0] vc_x;
    logic signed [FIELD_WIDTH-1:0] vc_y;
    logic signed [FIELD_WIDTH-1:0] vc_z;
    logic signed [FIELD_WIDTH-1:0] point_x;
    logic signed [FIELD_WIDTH-1:0] point_y;
    logic signed [FIELD_WIDTH-1:0] point_z;
  } bpt_in_t;

  typedef struct packed {
    logic signed [WEIGHT_WIDTH-1:0] weight_u;
    logic signed [WEIGHT_WIDTH-1:0] weight_v;
    logic signed [WEIGHT_WIDTH-1:0] weight_w;
    logic                           inside_res;
    logic                           degenerate;
  } bpt_out_t;

  // control that travels with an item; lane 0 is v, lane 1 is w
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic       in_tri;
    logic [1:0] ovf;
    logic [1:0] neg;
  } bpt_flags_t;

endpackage

`default_nettype wire

@@ design/bpt_front.sv @@
// ---------------------------------------------------------------------------
// bpt_front
// Seven-stage front end: edge vectors, dot products, denominator and the
// two numerators, inside test and the divider chain's start values.
// ---------------------------------------------------------------------------
`default_nettype none

module bpt_front #(
  parameter int unsigned COORD_WIDTH   = bpt_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = bpt_pkg::FRACTION_BITS_DEF,
  parameter int unsigned QB            = bpt_pkg::QUOT_BITS,
  parameter int unsigned WW            = 73
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  bpt_pkg::bpt_in_t         data_i,
  output bpt_pkg::bpt_flags_t      flags_o,
  output logic [WW-1:0]            den_o,
  output logic [1:0][WW-1:0]       rem_o,
  output logic [1:0][QB-1:0]       num_o
);
  import bpt_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned DIF = CW + 1;
  localparam int unsigned PRD = 2 * DIF;
  localparam int unsigned DOT = PRD + 2;
  localparam int unsigned H   = DOT / 2;
  localparam int unsigned LW  = DOT + H + 1;
  localparam int unsigned HW  = 2 * DOT - H;
  localparam int unsigned RW  = WW + FRACTION_BITS;
  localparam int unsigned EW  = RW + QB;
  localparam int unsigned IW  = WW + 2;
  // operand pairs: dot index 0 d00, 1 d01, 2 d11, 3 d20, 4 d21
  localparam int unsigned PA [6] = '{0, 1, 2, 1, 0, 1};
  localparam int unsigned PB [6] = '{2, 1, 3, 4, 4, 3};

  logic signed [CW-1:0]  c [12];
  logic [5:0]            vld_q;

  logic signed [DIF-1:0] e0_q [3];
  logic signed [DIF-1:0] e1_q [3];
  logic signed [DIF-1:0] p_q  [3];
  logic signed [PRD-1:0] m_q  [5][3];
  logic signed [DOT-1:0] dot_q [5];
  logic signed [LW-1:0]  lo_q [6];
  logic signed [HW-1:0]  hi_q [6];
  logic signed [WW-1:0]  full_q [6];
  logic signed [WW-1:0]  den_q, nv_q, nw_q;

  bpt_flags_t            flags_q;
  logic [WW-1:0]         den7_q;
  logic [1:0][WW-1:0]    rem_q;
  logic [1:0][QB-1:0]    num_q;

  // stage 7 combinational terms
  logic signed [WW-1:0]  nsel [2];
  logic [WW-1:0]         mag  [2];
  logic [EW-1:0]         ext  [2];
  logic [1:0]            ovf;
  logic signed [IW-1:0]  den_x, nv_x, nw_x, ns_x;
  logic                  degen, in_tri;

  // take the low coordinate bits of each field
  always_comb begin
    c[0]  = CW'($unsigned(data_i.va_x));
    c[1]  = CW'($unsigned(data_i.va_y));
    c[2]  = CW'($unsigned(data_i.va_z));
    c[3]  = CW'($unsigned(data_i.vb_x));
    c[4]  = CW'($unsigned(data_i.vb_y));
    c[5]  = CW'($unsigned(data_i.vb_z));
    c[6]  = CW'($unsigned(data_i.vc_x));
    c[7]  = CW'($unsigned(data_i.vc_y));
    c[8]  = CW'($unsigned(data_i.vc_z));
    c[9]  = CW'($unsigned(data_i.point_x));
    c[10] = CW'($unsigned(data_i.point_y));
    c[11] = CW'($unsigned(data_i.point_z));
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nsel[l] = (l == 0) ? nv_q : nw_q;
      mag[l]  = nsel[l][WW-1] ? WW'(-nsel[l]) : WW'(nsel[l]);
      ext[l]  = EW'(mag[l]) << FRACTION_BITS;
      ovf[l]  = ext[l][EW-1:QB] >= RW'(den_q);
    end
    den_x  = IW'(den_q);
    nv_x   = IW'(nv_q);
    nw_x   = IW'(nw_q);
    ns_x   = nv_x + nw_x;
    degen  = (den_q <= 0);
    in_tri = !degen && (nv_x >= 0) && (nw_x >= 0) && (den_x - nv_x >= 0) &&
             (den_x - nw_x >= 0) && (ns_x >= 0) && (den_x - ns_x >= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      flags_q <= '0;
    end else if (en_i) begin
      vld_q          <= {vld_q[4:0], valid_i};
      flags_q.valid  <= vld_q[5];
      flags_q.degen  <= degen;
      flags_q.in_tri <= in_tri;
      flags_q.ovf    <= ovf;
      flags_q.neg    <= {nw_q[WW-1], nv_q[WW-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        e0_q[i] <= DIF'(c[3 + i]) - DIF'(c[i]);
        e1_q[i] <= DIF'(c[6 + i]) - DIF'(c[i]);
        p_q[i]  <= DIF'(c[9 + i]) - DIF'(c[i]);
        m_q[0][i] <= PRD'(e0_q[i]) * PRD'(e0_q[i]);
        m_q[1][i] <= PRD'(e0_q[i]) * PRD'(e1_q[i]);
        m_q[2][i] <= PRD'(e1_q[i]) * PRD'(e1_q[i]);
        m_q[3][i] <= PRD'(p_q[i])  * PRD'(e0_q[i]);
        m_q[4][i] <= PRD'(p_q[i])  * PRD'(e1_q[i]);
      end
      for (int k = 0; k < 5; k++) begin
        dot_q[k] <= DOT'(m_q[k][0]) + DOT'(m_q[k][1]) + DOT'(m_q[k][2]);
      end
      // split the second operand so each multiplier stays narrow
      for (int k = 0; k < 6; k++) begin
        lo_q[k] <= LW'(dot_q[PA[k]]) * LW'($signed({1'b0, dot_q[PB[k]][H-1:0]}));
        hi_q[k] <= HW'(dot_q[PA[k]]) * HW'($signed(dot_q[PB[k]][DOT-1:H]));
        full_q[k] <= (WW'(hi_q[k]) <<< H) + WW'(lo_q[k]);
      end
      den_q <= full_q[0] - full_q[1];
      nv_q  <= full_q[2] - full_q[3];
      nw_q  <= full_q[4] - full_q[5];
      den7_q <= WW'(den_q);
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= ext[l][QB +: WW];
        num_q[l] <= ext[l][QB-1:0];
      end
    end
  end

  assign flags_o = flags_q;
  assign den_o   = den7_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;

endmodule

`default_nettype wire

@@ design/bpt_div_cell.sv @@
// ---------------------------------------------------------------------------
// bpt_div_cell
// One restoring division step for both weight lanes; hands its partial
// remainder, dividend bits and quotient to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module bpt_div_cell #(
  parameter int unsigned QB = 61,
  parameter int unsigned WW = 73
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  bpt_pkg::bpt_flags_t  flags_i,
  input  logic [WW-1:0]        den_i,
  input  logic [1:0][WW-1:0]   rem_i,
  input  logic [1:0][QB-1:0]   num_i,
  input  logic [1:0][QB-1:0]   quo_i,
  output bpt_pkg::bpt_flags_t  flags_o,
  output logic [WW-1:0]        den_o,
  output logic [1:0][WW-1:0]   rem_o,
  output logic [1:0][QB-1:0]   num_o,
  output logic [1:0][QB-1:0]   quo_o
);
  import bpt_pkg::*;

  bpt_flags_t          flags_q;
  logic [WW-1:0]       den_q;
  logic [1:0][WW-1:0]  rem_q, rem_d;
  logic [1:0][QB-1:0]  num_q, quo_q, quo_d;
  logic [WW:0]         trial [2];
  logic [1:0]          ge;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_i[l], num_i[l][QB-1]};
      ge[l]    = trial[l] >= {1'b0, den_i};
      rem_d[l] = ge[l] ? WW'(trial[l] - {1'b0, den_i}) : trial[l][WW-1:0];
      quo_d[l] = {quo_i[l][QB-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= num_i[l] << 1;
      end
    end
  end

  assign flags_o = flags_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign quo_o   = quo_q;

endmodule

`default_nettype wire

@@ design/triangle_barycentric_point_test_unit.sv @@
// ---------------------------------------------------------------------------
// triangle_barycentric_point_test_unit
// Barycentric weights and closed-range inside test for a point and a
// triangle given as signed integer coordinates.
// ---------------------------------------------------------------------------
// The unit takes one transfer per clock and returns one result transfer per
// input, in order. An item passes 69 registers, the first loaded by its
// input transfer: seven front stages (edge vectors, products, dot sums, split
// wide products, their sums, the denominator and numerators, then the inside
// test and divider setup), a row of 61 division cells that each settle one
// quotient bit of v and of w, and one output register that clips, forms u
// and saturates. Weights carry FRACTION_BITS fraction bits and truncate
// toward zero; a degenerate triangle (zero denominator) gives zero weights,
// a clear inside flag and a set degenerate flag. A stall on a waiting result
// holds the whole pipeline, so the input stalls in the same cycle; otherwise
// the rate is one per cycle.
`default_nettype none

module triangle_barycentric_point_test_unit #(
  parameter int unsigned COORD_WIDTH   = bpt_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = bpt_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bpt_pkg::bpt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bpt_pkg::bpt_out_t out_data_o
);
  import bpt_pkg::*;

  localparam int unsigned DOT = 2 * (COORD_WIDTH + 1) + 2;
  localparam int unsigned WW  = 2 * DOT + 1;
  localparam int unsigned QB  = QUOT_BITS;
  localparam int unsigned VW  = QB + 3;
  localparam logic [QB-1:0] QLIM = QB'(1) << (QB - 1);

  // the whole pipeline advances unless a finished result is held
  logic en;

  bpt_flags_t         flg [QB+1];
  logic [WW-1:0]      den [QB+1];
  logic [1:0][WW-1:0] rem [QB+1];
  logic [1:0][QB-1:0] num [QB+1];
  logic [1:0][QB-1:0] quo [QB+1];

  logic [QB-1:0]        mag [2];
  logic signed [VW-1:0] wgt [2];
  logic signed [VW-1:0] wu;
  bpt_out_t             res_d, res_q;
  logic                 out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  bpt_front #(
    .COORD_WIDTH  (COORD_WIDTH),
    .FRACTION_BITS(FRACTION_BITS),
    .QB           (QB),
    .WW           (WW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .flags_o(flg[0]),
    .den_o  (den[0]),
    .rem_o  (rem[0]),
    .num_o  (num[0])
  );

  assign quo[0] = '0;

  // one quotient bit per cell, most significant first
  for (genvar g = 0; g < QB; g++) begin : g_cell
    bpt_div_cell #(
      .QB(QB),
      .WW(WW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .flags_i(flg[g]),
      .den_i  (den[g]),
      .rem_i  (rem[g]),
      .num_i  (num[g]),
      .quo_i  (quo[g]),
      .flags_o(flg[g+1]),
      .den_o  (den[g+1]),
      .rem_o  (rem[g+1]),
      .num_o  (num[g+1]),
      .quo_o  (quo[g+1])
    );
  end

  function automatic logic signed [WEIGHT_WIDTH-1:0] sat_w(logic signed [VW-1:0] x);
    logic signed [VW-1:0] hi_lim, lo_lim;
    hi_lim = (VW'(1) <<< (WEIGHT_WIDTH - 1)) - VW'(1);
    lo_lim = -(VW'(1) <<< (WEIGHT_WIDTH - 1));
    if (x > hi_lim) begin
      return WEIGHT_WIDTH'(hi_lim);
    end else if (x < lo_lim) begin
      return WEIGHT_WIDTH'(lo_lim);
    end
    return WEIGHT_WIDTH'(x);
  endfunction

  // clip the quotient, restore the sign, form u and saturate
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l] = (flg[QB].ovf[l] || quo[QB][l] > QLIM) ? QLIM : quo[QB][l];
      wgt[l] = flg[QB].neg[l] ? -VW'(mag[l]) : VW'(mag[l]);
    end
    wu = (VW'(1) <<< FRACTION_BITS) - wgt[0] - wgt[1];
    if (flg[QB].degen) begin
      res_d = '0;
      res_d.degenerate = 1'b1;
    end else begin
      res_d.weight_u   = sat_w(wu);
      res_d.weight_v   = sat_w(wgt[0]);
      res_d.weight_w   = sat_w(wgt[1]);
      res_d.inside_res = flg[QB].in_tri;
      res_d.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= flg[QB].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

@@ design/bpt_checker.sv @@
// ---------------------------------------------------------------------------
// bpt_checker
// Port-level checks of the point test unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bpt_checker #(
  parameter int unsigned FRACTION_BITS = bpt_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_stall_i,
  input  bpt_pkg::bpt_out_t out_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i
);
  import bpt_pkg::*;

  localparam logic signed [WEIGHT_WIDTH-1:0] ONE = WEIGHT_WIDTH'(1) << FRACTION_BITS;

  logic held, degen_out, tri_out, zero_res, unit_res;

  assign held      = out_valid_i && out_stall_i;
  assign degen_out = out_valid_i && out_data_i.degenerate;
  assign tri_out   = out_valid_i && out_data_i.inside_res;
  assign zero_res  = out_data_i.weight_u == 0 && out_data_i.weight_v == 0 &&
                     out_data_i.weight_w == 0 && !out_data_i.inside_res;
  assign unit_res  = out_data_i.weight_u >= 0 && out_data_i.weight_u <= ONE &&
                     out_data_i.weight_v >= 0 && out_data_i.weight_v <= ONE &&
                     out_data_i.weight_w >= 0 && out_data_i.weight_w <= ONE;

  // hold a stalled result transfer
  `BPT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, held, out_valid_i, "result dropped while stalled")
  // stall the input exactly behind a held result
  `BPT_ASSERT(a_in_stall, clk_i, rst_ni, in_stall_i == held, "input stall without held result")
  // drop all weights on a degenerate triangle
  `BPT_ASSERT_IMP(a_degen, clk_i, rst_ni, degen_out, zero_res, "degenerate result has weights")
  // keep every weight of an inside point within zero and one
  `BPT_ASSERT_IMP(a_inside, clk_i, rst_ni, tri_out, unit_res, "inside weight out of range")

endmodule

bind triangle_barycentric_point_test_unit bpt_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_bpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_i (in_stall_o),
  .out_data_i (out_data_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i)
);

`default_nettype wire

@@ tb/triangle_barycentric_point_test_unit_test.sv @@
// ---------------------------------------------------------------------------
// Barycentric point test unit testbench
// Drives triangles and query points through the valid/stall input channel,
// predicts the weights and flags with exact wide integer arithmetic, and
// compares every result transfer in order under several idling phases.
// ---------------------------------------------------------------------------
`default_nettype none

class bary_scoreboard;
  bpt_pkg::bpt_out_t pending_q[$];
  int unsigned       errors;
  int unsigned       checked;
  int unsigned       degen_seen;
  int unsigned       inside_seen;

  // Quotient magnitude with the sign of the numerator, clipped at 2^60.
  function automatic longint ratio_fixed(logic signed [127:0] numer,
                                         logic signed [127:0] den);
    logic [127:0] mag;
    logic [127:0] quo;
    longint       m;
    mag = numer[127] ? -numer : numer;
    quo = (mag << 16) / den;
    m = (quo > (128'd1 << 60)) ? (64'sd1 <<< 60) : longint'(quo[63:0]);
    return numer[127] ? -m : m;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'sh7fffffff;
    if (x < -128'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Work out the expected weights for an accepted transfer and queue them.
  function void note_input(bpt_pkg::bpt_in_t item);
    logic signed [127:0] crd[12];
    logic signed [127:0] e0[3], e1[3], pv[3];
    logic signed [127:0] d00, d01, d11, d20, d21, den, nv, nw, ns;
    logic signed [127:0] v, w, u;
    bpt_pkg::bpt_out_t   res;
    logic [191:0]        flat;
    flat = item;
    for (int i = 0; i < 12; i++) begin
      crd[i] = $signed(flat[191 - 16*i -: 16]);
    end
    d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
    for (int i = 0; i < 3; i++) begin
      e0[i] = crd[3+i] - crd[i];
      e1[i] = crd[6+i] - crd[i];
      pv[i] = crd[9+i] - crd[i];
      d00 += e0[i] * e0[i];
      d01 += e0[i] * e1[i];
      d11 += e1[i] * e1[i];
      d20 += pv[i] * e0[i];
      d21 += pv[i] * e1[i];
    end
    den = d00 * d11 - d01 * d01;
    nv  = d11 * d20 - d01 * d21;
    nw  = d00 * d21 - d01 * d20;
    res = '0;
    if (den <= 0) begin
      res.degenerate = 1'b1;
    end else begin
      v  = ratio_fixed(nv, den);
      w  = ratio_fixed(nw, den);
      u  = (128'sd1 <<< 16) - v - w;
      ns = nv + nw;
      res.weight_u   = clip32(u);
      res.weight_v   = clip32(v);
      res.weight_w   = clip32(w);
      res.inside_res = (nv >= 0) && (nw >= 0) && (nv <= den) && (nw <= den) &&
                       (ns >= 0) && (ns <= den);
    end
    pending_q.push_back(res);
  endfunction

  function void check_result(bpt_pkg::bpt_out_t got);
    bpt_pkg::bpt_out_t want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    checked++;
    if (got.degenerate) degen_seen++;
    if (got.inside_res) inside_seen++;
    if (got.weight_u !== want.weight_u) begin
      $display("%0t: weight_u expected %h actual %h", $time, want.weight_u, got.weight_u);
      errors++;
    end
    if (got.weight_v !== want.weight_v) begin
      $display("%0t: weight_v expected %h actual %h", $time, want.weight_v, got.weight_v);
      errors++;
    end
    if (got.weight_w !== want.weight_w) begin
      $display("%0t: weight_w expected %h actual %h", $time, want.weight_w, got.weight_w);
      errors++;
    end
    if (got.inside_res !== want.inside_res) begin
      $display("%0t: inside_res expected %b actual %b", $time, want.inside_res,
               got.inside_res);
      errors++;
    end
    if (got.degenerate !== want.degenerate) begin
      $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
               got.degenerate);
      errors++;
    end
  endfunction
endclass

module triangle_barycentric_point_test_unit_test;
  import bpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_LATENCY = 69;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  bpt_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  bpt_out_t out_data_o;

  bary_scoreboard board = new();

  // Idle percentages of each side; the long hold-off overrides the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;

  triangle_barycentric_point_test_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: end the run if the pipeline locks up.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: check each result transfer, then pick the next stall value.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one item, holding it steady until the transfer happens.
  task automatic send_item(bpt_in_t item);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(item);
    sent++;
  endtask

  function automatic logic signed [15:0] pick_coord(int unsigned span);
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return span == 0 ? 16'($urandom) :
                      16'($signed($urandom_range(2*span)) - $signed(span));
    endcase
  endfunction

  // Random triangle: mostly well-formed, some degenerate, some wild.
  function automatic bpt_in_t make_item();
    bpt_in_t     t;
    int unsigned kind;
    int unsigned span;
    kind = $urandom_range(9);
    span = ($urandom_range(3) == 0) ? 0 : $urandom_range(3, 200);
    t.va_x = pick_coord(span); t.va_y = pick_coord(span);
    t.va_z = pick_coord(span);
    t.vb_x = pick_coord(span); t.vb_y = pick_coord(span);
    t.vb_z = pick_coord(span);
    t.vc_x = pick_coord(span); t.vc_y = pick_coord(span);
    t.vc_z = pick_coord(span);
    t.point_x = pick_coord(span); t.point_y = pick_coord(span);
    t.point_z = pick_coord(span);
    if (kind == 0) begin
      // Collapse a vertex onto another to make the triangle degenerate.
      t.vc_x = t.vb_x; t.vc_y = t.vb_y; t.vc_z = t.vb_z;
    end else if (kind < 6) begin
      // Place the point inside or near the triangle as a weighted mix.
      int a, b;
      a = $urandom_range(12); b = $urandom_range(12 - a);
      t.point_x = 16'((12*t.va_x + a*(t.vb_x - t.va_x) +
                       b*(t.vc_x - t.va_x)) / 12);
      t.point_y = 16'((12*t.va_y + a*(t.vb_y - t.va_y) +
                       b*(t.vc_y - t.va_y)) / 12);
      t.point_z = t.va_z;
    end
    return t;
  endfunction

  function automatic bpt_in_t tri_of(int ax, int ay, int bx, int by, int cx, int cy,
                                      int px, int py);
    bpt_in_t t;
    t = '0;
    t.va_x = 16'(ax); t.va_y = 16'(ay);
    t.vb_x = 16'(bx); t.vb_y = 16'(by);
    t.vc_x = 16'(cx); t.vc_y = 16'(cy);
    t.point_x = 16'(px); t.point_y = 16'(py);
    return t;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    bpt_in_t t;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corners, edges, outside, degenerate, extreme coordinates.
    send_item(tri_of(0, 0, 100, 0, 0, 100, 0, 0));
    send_item(tri_of(0, 0, 100, 0, 0, 100, 100, 0));
    send_item(tri_of(0, 0, 100, 0, 0, 100, 0, 100));
    send_item(tri_of(0, 0, 100, 0, 0, 100, 50, 50));
    send_item(tri_of(0, 0, 100, 0, 0, 100, 33, 33));
    send_item(tri_of(0, 0, 100, 0, 0, 100, 51, 50));
    send_item(tri_of(0, 0, 100, 0, 0, 100, -1, 5));
    send_item(tri_of(0, 0, 3, 0, 0, 7, 1, 1));
    send_item(tri_of(5, 5, 5, 5, 5, 5, 1, 2));
    send_item(tri_of(0, 0, 10, 10, 20, 20, 5, 5));
    send_item(tri_of(0, 0, 1, 0, 0, 1, 32767, -32768));
    send_item(tri_of(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    send_item(tri_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_item(tri_of(0, 0, 1, 0, 0, 1, -32768, -32768));
    t = '1;
    send_item(t);
    t = '0;
    send_item(t);
    t = {12{16'sh8000}};
    t.vb_z = 16'sh7fff; t.vc_y = 16'sh7fff; t.point_x = 16'sh7fff;
    send_item(t);
    t = {12{16'sh5555}};
    t.vb_x = 16'shaaaa; t.vc_z = 16'shaaaa; t.point_y = 16'shaaaa;
    send_item(t);
    drain();

    // Random phases: none, sender idle, receiver stalling, both light.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 7 : 0;
      recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 7 : 0;
      for (int i = 0; i < 380; i++) begin
        // Hold off the receiver for a long stretch so the pipeline fills.
        if (ph == 0 && i == 100) hold_cycles = 300;
        // Alternate stretches with and without idling.
        if (ph == 3 && (i % 100) == 50) begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end else if (ph == 3 && (i % 100) == 0) begin
          send_idle_pct = 7; recv_stall_pct = 7;
        end
        send_item(make_item());
      end
    end
    drain();

    $display("Sent %0d triangles, checked %0d results: %0d inside, %0d degenerate.",
             sent, board.checked, board.inside_seen, board.degen_seen);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
